// ----- design/tfbt_pkg.sv -----
// shared types and constants of the track flash boundary tagger
// no dependencies; the other design files but tfbt_ram and tfbt_checker refer to this package by scoped names
`default_nettype none

package tfbt_pkg;

	// item operation codes
	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_ADD   = 2'd1,
		OP_TRACK = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// configuration register indexes
	localparam logic [2:0] REG_CHARGE_THRESHOLD = 3'd0;
	localparam logic [2:0] REG_MIN_LENGTH       = 3'd1;
	localparam logic [2:0] REG_ANODE_REF        = 3'd2;
	localparam logic [2:0] REG_CATHODE_REF      = 3'd3;
	localparam logic [2:0] REG_ANODE_WIN        = 3'd4;
	localparam logic [2:0] REG_CATHODE_WIN      = 3'd5;
	localparam logic [2:0] REG_Z_WIN            = 3'd6;
	localparam logic [2:0] REG_INV_DRIFT        = 3'd7;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// offset arithmetic widths (values scaled by 2^16)
	localparam int PROD_W = 41;
	localparam int OFFS_W = 42;
	localparam int DIST_W = 43;

	typedef struct packed {
		logic        [15:0] charge_threshold;
		logic        [15:0] min_length;
		logic signed [18:0] anode_ref;
		logic signed [18:0] cathode_ref;
		logic        [17:0] anode_time_window;
		logic        [17:0] cathode_time_window;
		logic        [14:0] z_window;
		logic        [23:0] inverse_drift;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_OFFS,
		ST_SCAN,
		ST_DRAIN,
		ST_JUDGE
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load_track;
		logic mul_en;
		logic offs_en;
		logic wr_en;
		logic rd_en;
		logic out_load;
		logic table_empty;
		logic overflow;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic charge_pass;
	} status_t;

endpackage

`default_nettype wire

// ----- design/tfbt_ram.sv -----
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module tfbt_ram #(
	parameter int WIDTH = 35,
	parameter int DEPTH = 64
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic                                    re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- design/tfbt_regs.sv -----
// configuration register file
// depends on tfbt_pkg
`default_nettype none

module tfbt_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [tfbt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tfbt_pkg::CFG_DATA_W-1:0] cfg_data,
	output tfbt_pkg::cfg_t                      cfg
);

	tfbt_pkg::cfg_t cfg_q;

	// register writes, decoded by index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.charge_threshold    <= 16'd0;
			cfg_q.min_length          <= 16'd0;
			cfg_q.anode_ref           <= 19'sd8;
			cfg_q.cathode_ref         <= 19'sd36656;
			cfg_q.anode_time_window   <= 18'd80;
			cfg_q.cathode_time_window <= 18'd80;
			cfg_q.z_window            <= 15'd1280;
			cfg_q.inverse_drift       <= 24'd589824;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tfbt_pkg::REG_CHARGE_THRESHOLD: cfg_q.charge_threshold <= cfg_data[15:0];
				tfbt_pkg::REG_MIN_LENGTH:       cfg_q.min_length <= cfg_data[15:0];
				tfbt_pkg::REG_ANODE_REF:        cfg_q.anode_ref <= cfg_data[18:0];
				tfbt_pkg::REG_CATHODE_REF:      cfg_q.cathode_ref <= cfg_data[18:0];
				tfbt_pkg::REG_ANODE_WIN:        cfg_q.anode_time_window <= cfg_data[17:0];
				tfbt_pkg::REG_CATHODE_WIN:      cfg_q.cathode_time_window <= cfg_data[17:0];
				tfbt_pkg::REG_Z_WIN:            cfg_q.z_window <= cfg_data[14:0];
				tfbt_pkg::REG_INV_DRIFT:        cfg_q.inverse_drift <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- design/tfbt_ctrl.sv -----
// controller: flash table bookkeeping and track scan sequencing
// depends on tfbt_pkg
`default_nettype none

module tfbt_ctrl #(
	parameter int FLASH_SLOTS = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [1:0]          op,
	output logic                     out_valid,
	input  wire logic                out_stall,
	input  wire tfbt_pkg::status_t   status,
	output tfbt_pkg::cmd_t           cmd,
	output logic [(FLASH_SLOTS > 1 ? $clog2(FLASH_SLOTS) : 1)-1:0] waddr,
	output logic [(FLASH_SLOTS > 1 ? $clog2(FLASH_SLOTS) : 1)-1:0] raddr
);

	localparam int AW = FLASH_SLOTS > 1 ? $clog2(FLASH_SLOTS) : 1;
	localparam int CW = $clog2(FLASH_SLOTS + 1);
	localparam logic [CW-1:0] SLOTS_C = CW'(FLASH_SLOTS);

	tfbt_pkg::state_t state_q, state_d;
	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic [CW-1:0] scan_q;
	logic          drain_q;
	logic          out_valid_q;
	logic          accept;
	logic          scan_last;
	logic          out_free;
	logic          empty;

	assign accept    = in_valid && !in_stall;
	assign empty     = (count_q == '0);
	assign scan_last = ((scan_q + CW'(1)) == count_q);
	assign out_free  = !out_valid_q || !out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tfbt_pkg::ST_IDLE: begin
				if (accept && (op == tfbt_pkg::OP_TRACK)) state_d = tfbt_pkg::ST_MUL;
			end
			tfbt_pkg::ST_MUL: state_d = tfbt_pkg::ST_OFFS;
			tfbt_pkg::ST_OFFS: state_d = empty ? tfbt_pkg::ST_JUDGE : tfbt_pkg::ST_SCAN;
			tfbt_pkg::ST_SCAN: begin
				if (scan_last) state_d = tfbt_pkg::ST_DRAIN;
			end
			tfbt_pkg::ST_DRAIN: begin
				if (drain_q) state_d = tfbt_pkg::ST_JUDGE;
			end
			tfbt_pkg::ST_JUDGE: begin
				if (out_free) state_d = tfbt_pkg::ST_IDLE;
			end
			default: state_d = tfbt_pkg::ST_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd             = '0;
		cmd.load_track  = accept && (op == tfbt_pkg::OP_TRACK);
		cmd.wr_en       = accept && (op == tfbt_pkg::OP_ADD) && status.charge_pass
			&& (count_q != SLOTS_C);
		cmd.mul_en      = (state_q == tfbt_pkg::ST_MUL);
		cmd.offs_en     = (state_q == tfbt_pkg::ST_OFFS);
		cmd.rd_en       = (state_q == tfbt_pkg::ST_SCAN);
		cmd.out_load    = (state_q == tfbt_pkg::ST_JUDGE) && out_free;
		cmd.table_empty = empty;
		cmd.overflow    = ovf_q;
	end

	assign in_stall  = (state_q != tfbt_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign waddr     = count_q[AW-1:0];
	assign raddr     = scan_q[AW-1:0];

	// state, table bookkeeping and scan counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tfbt_pkg::ST_IDLE;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			scan_q      <= '0;
			drain_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && (op == tfbt_pkg::OP_CLEAR)) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else if (accept && (op == tfbt_pkg::OP_ADD) && status.charge_pass) begin
				if (count_q == SLOTS_C) ovf_q <= 1'b1;
				else count_q <= count_q + CW'(1);
			end
			if (state_q == tfbt_pkg::ST_SCAN) scan_q <= scan_q + CW'(1);
			else scan_q <= '0;
			drain_q <= (state_q == tfbt_pkg::ST_DRAIN) && !drain_q;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ----- design/tfbt_dp.sv -----
// datapath: flash memory, offset arithmetic, closest flash search, result register
// depends on tfbt_pkg and tfbt_ram
`default_nettype none

module tfbt_dp #(
	parameter int FLASH_SLOTS = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire tfbt_pkg::cfg_t      cfg,
	input  wire tfbt_pkg::cmd_t      cmd,
	output tfbt_pkg::status_t        status,
	input  wire logic [(FLASH_SLOTS > 1 ? $clog2(FLASH_SLOTS) : 1)-1:0] waddr,
	input  wire logic [(FLASH_SLOTS > 1 ? $clog2(FLASH_SLOTS) : 1)-1:0] raddr,
	input  wire logic signed [18:0]  flash_time,
	input  wire logic signed [15:0]  flash_z,
	input  wire logic        [15:0]  flash_charge,
	input  wire logic signed [15:0]  start_x,
	input  wire logic signed [15:0]  start_y,
	input  wire logic signed [15:0]  start_z,
	input  wire logic signed [15:0]  end_x,
	input  wire logic signed [15:0]  end_y,
	input  wire logic signed [15:0]  end_z,
	input  wire logic        [15:0]  track_length,
	output logic                     tagged_res,
	output logic                     length_ok,
	output logic             [3:0]   test_mask,
	output logic                     table_empty,
	output logic                     flash_overflow
);

	localparam int PW = tfbt_pkg::PROD_W;
	localparam int OW = tfbt_pkg::OFFS_W;
	localparam int DW = tfbt_pkg::DIST_W;

	// track registers
	logic signed [15:0] xa_q, xc_q;
	logic signed [16:0] zsum_q;
	logic               pos_q, len_ok_q;
	logic signed [PW-1:0] prod_a_q, prod_c_q;
	logic signed [OW-1:0] off_a_q, off_c_q;

	// scan pipeline
	logic               v_s1, v_s2;
	logic [34:0]        rdata;
	logic signed [18:0] rt;
	logic signed [15:0] rz;
	logic [DW-1:0]      dist_a_s2, dist_c_s2;
	logic signed [15:0] z_s2;
	logic               found_a_q, found_c_q;
	logic [DW-1:0]      best_a_q, best_c_q;
	logic signed [15:0] bz_a_q, bz_c_q;

	// result register
	logic       tagged_q, len_q, empty_q, ovf_q;
	logic [3:0] mask_q;

	logic signed [16:0] dx;
	logic               start_top;
	logic signed [15:0] top_x, bot_x;
	logic signed [OW-1:0] ref_a_ext, ref_c_ext;
	logic signed [DW-1:0] t_ext, diff_a, diff_c;
	logic [DW-1:0]      abs_a, abs_c;
	logic               hit_a, hit_c;
	logic [3:0]         mask_d;

	assign status.charge_pass = (flash_charge > cfg.charge_threshold);

	// flash table storage, time and z packed together
	tfbt_ram #(
		.WIDTH(35),
		.DEPTH(FLASH_SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (cmd.wr_en),
		.waddr(waddr),
		.wdata({flash_time, flash_z}),
		.re   (cmd.rd_en),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign rt = rdata[34:16];
	assign rz = rdata[15:0];

	// orientation: start is top only if its y is strictly higher
	assign start_top = (start_y > end_y);
	assign top_x     = start_top ? start_x : end_x;
	assign bot_x     = start_top ? end_x : start_x;
	assign dx        = 17'(bot_x) - 17'(top_x);

	// latch track, anode lane uses top x when drifting positive
	always_ff @(posedge clk) begin
		if (cmd.load_track) begin
			pos_q    <= !dx[16] && (dx != 17'sd0);
			xa_q     <= (!dx[16] && (dx != 17'sd0)) ? top_x : bot_x;
			xc_q     <= (!dx[16] && (dx != 17'sd0)) ? bot_x : top_x;
			zsum_q   <= 17'(start_z) + 17'(end_z);
			len_ok_q <= (track_length >= cfg.min_length);
		end
	end

	// x times inverse drift, then reference removed
	assign ref_a_ext = OW'(signed'({cfg.anode_ref, 16'h0}));
	assign ref_c_ext = OW'(signed'({cfg.cathode_ref, 16'h0}));

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_a_q <= PW'(xa_q * signed'({1'b0, cfg.inverse_drift}));
			prod_c_q <= PW'(xc_q * signed'({1'b0, cfg.inverse_drift}));
		end
		if (cmd.offs_en) begin
			off_a_q <= OW'(prod_a_q) - ref_a_ext;
			off_c_q <= OW'(prod_c_q) - ref_c_ext;
		end
	end

	// distance of one flash from each lane's offset
	assign t_ext  = DW'(signed'({rt, 16'h0}));
	assign diff_a = DW'(off_a_q) - t_ext;
	assign diff_c = DW'(off_c_q) - t_ext;
	assign abs_a  = diff_a[DW-1] ? DW'(-diff_a) : DW'(diff_a);
	assign abs_c  = diff_c[DW-1] ? DW'(-diff_c) : DW'(diff_c);

	always_ff @(posedge clk) begin
		if (v_s1) begin
			dist_a_s2 <= abs_a;
			dist_c_s2 <= abs_c;
			z_s2      <= rz;
		end
	end

	// running minimum, first flash kept on ties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			found_a_q <= 1'b0;
			found_c_q <= 1'b0;
		end else begin
			v_s1 <= cmd.rd_en;
			v_s2 <= v_s1;
			if (cmd.offs_en) begin
				found_a_q <= 1'b0;
				found_c_q <= 1'b0;
			end else if (v_s2) begin
				if (!found_a_q || (dist_a_s2 < best_a_q)) found_a_q <= 1'b1;
				if (!found_c_q || (dist_c_s2 < best_c_q)) found_c_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && (!found_a_q || (dist_a_s2 < best_a_q))) begin
			best_a_q <= dist_a_s2;
			bz_a_q   <= z_s2;
		end
		if (v_s2 && (!found_c_q || (dist_c_s2 < best_c_q))) begin
			best_c_q <= dist_c_s2;
			bz_c_q   <= z_s2;
		end
	end

	// window tests on the best flash of each lane
	function automatic logic z_pass(input logic signed [16:0] zsum,
		input logic signed [15:0] z, input logic [14:0] zw);
		logic signed [17:0] dz2;
		logic signed [17:0] zw2;
		begin
			dz2 = 18'(zsum) - 18'(signed'({z, 1'b0}));
			zw2 = signed'({2'b00, zw, 1'b0});
			z_pass = (dz2 > -zw2) && (dz2 < zw2);
		end
	endfunction

	assign hit_a = found_a_q && (best_a_q < DW'({cfg.anode_time_window, 16'h0}))
		&& z_pass(zsum_q, bz_a_q, cfg.z_window);
	assign hit_c = found_c_q && (best_c_q < DW'({cfg.cathode_time_window, 16'h0}))
		&& z_pass(zsum_q, bz_c_q, cfg.z_window);

	assign mask_d = !len_ok_q ? 4'b0000 :
		pos_q ? {hit_c, 1'b0, 1'b0, hit_a} : {1'b0, hit_c, hit_a, 1'b0};

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			mask_q   <= mask_d;
			tagged_q <= (mask_d != 4'b0000);
			len_q    <= len_ok_q;
			empty_q  <= cmd.table_empty;
			ovf_q    <= cmd.overflow;
		end
	end

	assign tagged_res     = tagged_q;
	assign length_ok      = len_q;
	assign test_mask      = mask_q;
	assign table_empty    = empty_q;
	assign flash_overflow = ovf_q;

endmodule

`default_nettype wire

// ----- design/track_flash_boundary_tagger_core.sv -----
// top level of the track flash boundary tagger
// depends on tfbt_pkg, tfbt_regs, tfbt_ctrl, tfbt_dp, tfbt_ram
//
//  channel | handshake            | payload
//  cfg     | cfg_we               | cfg_index, cfg_data
//  in      | in_valid / in_stall  | op, flash_*, start_*, end_*, track_length
//  out     | out_valid / out_stall| tagged_res, length_ok, test_mask, table_empty, flash_overflow
//
// clear and add requests leave the input free; a track request steps through the mul,
// offs, scan, drain and judge states (scan and drain skipped with an empty table), the
// scan reading one stored flash per cycle from the ram. input is stalled while a track
// is in work, and longer while a finished track waits for a stalled result to leave the
// output register; a finished result waits there while the next request is taken.
// reset empties the table; no clearing pass.
`default_nettype none

module track_flash_boundary_tagger_core #(
	parameter int FLASH_SLOTS = 64
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [tfbt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [tfbt_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [1:0]                       op,
	input  wire logic signed [18:0]               flash_time,
	input  wire logic signed [15:0]               flash_z,
	input  wire logic        [15:0]               flash_charge,
	input  wire logic signed [15:0]               start_x,
	input  wire logic signed [15:0]               start_y,
	input  wire logic signed [15:0]               start_z,
	input  wire logic signed [15:0]               end_x,
	input  wire logic signed [15:0]               end_y,
	input  wire logic signed [15:0]               end_z,
	input  wire logic        [15:0]               track_length,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic                                  tagged_res,
	output logic                                  length_ok,
	output logic             [3:0]                test_mask,
	output logic                                  table_empty,
	output logic                                  flash_overflow
);

	localparam int AW = FLASH_SLOTS > 1 ? $clog2(FLASH_SLOTS) : 1;

	tfbt_pkg::cfg_t    cfg;
	tfbt_pkg::cmd_t    cmd;
	tfbt_pkg::status_t status;
	logic [AW-1:0]     waddr, raddr;

	tfbt_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	tfbt_ctrl #(.FLASH_SLOTS(FLASH_SLOTS)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.op       (op),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status   (status),
		.cmd      (cmd),
		.waddr    (waddr),
		.raddr    (raddr)
	);

	tfbt_dp #(.FLASH_SLOTS(FLASH_SLOTS)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.cmd           (cmd),
		.status        (status),
		.waddr         (waddr),
		.raddr         (raddr),
		.flash_time    (flash_time),
		.flash_z       (flash_z),
		.flash_charge  (flash_charge),
		.start_x       (start_x),
		.start_y       (start_y),
		.start_z       (start_z),
		.end_x         (end_x),
		.end_y         (end_y),
		.end_z         (end_z),
		.track_length  (track_length),
		.tagged_res    (tagged_res),
		.length_ok     (length_ok),
		.test_mask     (test_mask),
		.table_empty   (table_empty),
		.flash_overflow(flash_overflow)
	);

endmodule

`default_nettype wire

// ----- design/tfbt_checker.sv -----
// port level checks of the track flash boundary tagger, bound to the top level
// depends on track_flash_boundary_tagger_core ports only
`default_nettype none

module tfbt_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic       tagged_res,
	input wire logic       length_ok,
	input wire logic [3:0] test_mask,
	input wire logic       table_empty
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// tag flag agrees with the mask
	a_tag_mask: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (tagged_res == (test_mask != 4'b0000)))
		else $error("tag flag disagrees with mask");

	// short tracks and empty tables give no tag
	a_no_tag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (!length_ok || table_empty) |-> (test_mask == 4'b0000))
		else $error("tag given without length or flashes");

	// a new result only follows a busy cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without track in work");

endmodule

bind track_flash_boundary_tagger_core tfbt_checker u_tfbt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.tagged_res (tagged_res),
	.length_ok  (length_ok),
	.test_mask  (test_mask),
	.table_empty(table_empty)
);

`default_nettype wire

// ----- tb/tfbt_checker.sv -----
// monitor for the track flash boundary tagger: watches the in and out channels, predicts tags
// depends on tfbt_pkg; configuration is mirrored from the write port
`default_nettype none

module tfbt_monitor #(
	parameter int FLASH_SLOTS = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [23:0]        cfg_data,
	input  wire logic               in_valid,
	input  wire logic               in_stall,
	input  wire logic [1:0]         op,
	input  wire logic signed [18:0] flash_time,
	input  wire logic signed [15:0] flash_z,
	input  wire logic [15:0]        flash_charge,
	input  wire logic signed [15:0] start_x,
	input  wire logic signed [15:0] start_y,
	input  wire logic signed [15:0] start_z,
	input  wire logic signed [15:0] end_x,
	input  wire logic signed [15:0] end_y,
	input  wire logic signed [15:0] end_z,
	input  wire logic [15:0]        track_length,
	input  wire logic               out_valid,
	input  wire logic               out_stall,
	input  wire logic               tagged_res,
	input  wire logic               length_ok,
	input  wire logic [3:0]         test_mask,
	input  wire logic               table_empty,
	input  wire logic               flash_overflow,
	output int                      fail_count,
	output int                      pending_tags
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic       hit;
		logic       len_ok;
		logic [3:0] mask;
		logic       empty;
		logic       ovf;
	} tag_t;

	tag_t             tag_q[$];
	longint           flash_t[FLASH_SLOTS];
	longint           flash_zc[FLASH_SLOTS];
	int               n_flash;
	bit               ovf_seen;
	tfbt_pkg::cfg_t   cfg;

	// closest flash to a reference, then time and z window tests
	function automatic bit cross_test(longint x, longint ref_v, longint twin, longint zsum);
		longint reco, d, best;
		int     idx;
		reco = x * longint'(cfg.inverse_drift);
		idx = -1;
		best = 0;
		for (int i = 0; i < n_flash; i++) begin
			d = reco - flash_t[i] * 65536 - ref_v * 65536;
			if (d < 0) d = -d;
			if (idx < 0 || d < best) begin
				best = d;
				idx = i;
			end
		end
		if (idx < 0) return 0;
		if (!(best < twin * 65536)) return 0;
		d = zsum - 2 * flash_zc[idx];
		return d > -2 * longint'(cfg.z_window) && d < 2 * longint'(cfg.z_window);
	endfunction

	function automatic tag_t predict_tag();
		tag_t   r;
		longint tx, bx, zs;
		bit     pos;
		r = '0;
		r.len_ok = track_length >= cfg.min_length;
		if (r.len_ok) begin
			tx = (start_y > end_y) ? start_x : end_x;
			bx = (start_y > end_y) ? end_x : start_x;
			zs = longint'(start_z) + longint'(end_z);
			pos = (bx - tx) > 0;
			r.mask[0] = pos && cross_test(tx, cfg.anode_ref, cfg.anode_time_window, zs);
			r.mask[1] = !pos && cross_test(bx, cfg.anode_ref, cfg.anode_time_window, zs);
			r.mask[2] = !pos && cross_test(tx, cfg.cathode_ref, cfg.cathode_time_window, zs);
			r.mask[3] = pos && cross_test(bx, cfg.cathode_ref, cfg.cathode_time_window, zs);
		end
		r.hit = r.mask != 0;
		r.empty = n_flash == 0;
		r.ovf = ovf_seen;
		return r;
	endfunction

	assign pending_tags = tag_q.size();

	always @(posedge clk or negedge arst_n) begin
		tag_t exp_t, got;
		if (!arst_n) begin
			fail_count <= 0;
			n_flash = 0;
			ovf_seen = 0;
			cfg = '{16'd0, 16'd0, 19'sd8, 19'sd36656, 18'd80, 18'd80, 15'd1280, 24'd589824};
			tag_q.delete();
		end else begin
			// mirror register writes
			if (cfg_we) begin
				case (cfg_index)
					tfbt_pkg::REG_CHARGE_THRESHOLD: cfg.charge_threshold = cfg_data[15:0];
					tfbt_pkg::REG_MIN_LENGTH:       cfg.min_length = cfg_data[15:0];
					tfbt_pkg::REG_ANODE_REF:        cfg.anode_ref = cfg_data[18:0];
					tfbt_pkg::REG_CATHODE_REF:      cfg.cathode_ref = cfg_data[18:0];
					tfbt_pkg::REG_ANODE_WIN:        cfg.anode_time_window = cfg_data[17:0];
					tfbt_pkg::REG_CATHODE_WIN:      cfg.cathode_time_window = cfg_data[17:0];
					tfbt_pkg::REG_Z_WIN:            cfg.z_window = cfg_data[14:0];
					tfbt_pkg::REG_INV_DRIFT:        cfg.inverse_drift = cfg_data[23:0];
					default: ;
				endcase
			end
			// accepted request
			if (in_valid && !in_stall) begin
				case (tfbt_pkg::op_t'(op))
					tfbt_pkg::OP_CLEAR: begin
						n_flash = 0;
						ovf_seen = 0;
					end
					tfbt_pkg::OP_ADD: if (flash_charge > cfg.charge_threshold) begin
						if (n_flash >= FLASH_SLOTS) ovf_seen = 1;
						else begin
							flash_t[n_flash] = flash_time;
							flash_zc[n_flash] = flash_z;
							n_flash++;
						end
					end
					tfbt_pkg::OP_TRACK: tag_q = {tag_q, predict_tag()};
					default: ;
				endcase
			end
			// accepted result
			if (out_valid && !out_stall) begin
				got = '{tagged_res, length_ok, test_mask, table_empty, flash_overflow};
				if (tag_q.size() == 0) begin
					$display("%0t: unexpected result %b", $time, got);
					fail_count <= fail_count + 1;
				end else begin
					exp_t = tag_q.pop_front();
					if (got !== exp_t) begin
						$display("%0t: mismatch tagged %b/%b len_ok %b/%b mask %h/%h empty %b/%b ovf %b/%b",
							$time, exp_t.hit, got.hit, exp_t.len_ok, got.len_ok,
							exp_t.mask, got.mask, exp_t.empty, got.empty, exp_t.ovf, got.ovf);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

`default_nettype wire

// ----- tb/tb_track_flash_boundary_tagger_core.sv -----
// testbench top of the track flash boundary tagger: clock, reset, stimulus, verdict
// depends on tfbt_pkg, track_flash_boundary_tagger_core and tfbt_monitor
`default_nettype none

module tb_track_flash_boundary_tagger_core;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 0, arst_n = 0;
	logic cfg_we = 0;
	logic [2:0] cfg_index = '0;
	logic [23:0] cfg_data = '0;
	logic in_valid = 0, out_stall = 0;
	logic [1:0] op = '0;
	logic signed [18:0] flash_time = '0;
	logic signed [15:0] flash_z = '0, start_x = '0, start_y = '0, start_z = '0;
	logic signed [15:0] end_x = '0, end_y = '0, end_z = '0;
	logic [15:0] flash_charge = '0, track_length = '0;
	logic in_stall, out_valid, tagged_res, length_ok, table_empty, flash_overflow;
	logic [3:0] test_mask;
	int fail_count, pending_tags;
	bit quiet;

	always #2 clk = ~clk;

	track_flash_boundary_tagger_core uut (.*);
	tfbt_monitor chk (.*);

	// receiver stalls at random except in the quiet stretch
	always @(posedge clk) out_stall <= !quiet && ($urandom_range(99) < 7);

	// write enable stays high across back to back writes; caller lowers it
	task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	// present one request and hold it until accepted
	task automatic send_req(input logic [1:0] o, input logic signed [18:0] ft,
		input logic signed [15:0] fz, input logic [15:0] fc,
		input logic signed [15:0] sx, sy, sz, ex, ey, ez, input logic [15:0] len);
		while (!quiet && $urandom_range(99) < 7) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		op <= o; flash_time <= ft; flash_z <= fz; flash_charge <= fc;
		start_x <= sx; start_y <= sy; start_z <= sz;
		end_x <= ex; end_y <= ey; end_z <= ez; track_length <= len;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// random request of the given op with every field random
	task automatic rand_req(input logic [1:0] o);
		send_req(o, 19'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), 16'($urandom));
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending_tags != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic add_flash(input logic signed [18:0] ft, input logic signed [15:0] fz,
		input logic [15:0] fc);
		send_req(tfbt_pkg::OP_ADD, ft, fz, fc, 0, 0, 0, 0, 0, 0, 0);
	endtask

	// track whose x lands near the reference offset of flashes near time zero when near is set
	task automatic rand_track(input int near);
		logic signed [15:0] sx, ex, sz;
		sx = 16'($urandom); ex = 16'($urandom); sz = 16'($urandom);
		if (near) begin
			sx = 16'($urandom_range(0, 40));
			ex = 16'(sx + $signed($urandom_range(0, 20)) - 10);
			sz = 16'($signed($urandom_range(0, 400)) - 200);
		end
		send_req(tfbt_pkg::OP_TRACK, 0, 0, 0, sx, 16'($urandom), sz, ex, 16'($urandom),
			16'(near ? -sz + $signed($urandom_range(0, 60)) - 30 : $urandom),
			$urandom_range(0, 1) ? 16'hffff : 16'($urandom));
	endtask

	task automatic rand_flash(input int near);
		if (near) add_flash(19'($signed($urandom_range(0, 120)) - 60),
			16'($signed($urandom_range(0, 200)) - 100), 16'($urandom));
		else add_flash(19'($urandom), 16'($urandom), 16'($urandom));
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty table, op 3, ties, overflow, field extremes
		send_req(tfbt_pkg::OP_TRACK, 0, 0, 0, 10, 5, 0, 20, 5, 0, 16'hffff);
		send_req(tfbt_pkg::OP_NONE, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1);
		add_flash(19'sh3ffff, 16'sh7fff, 16'hffff);
		add_flash(19'sh40000, 16'sh8000, 16'h0001);
		add_flash(0, 0, 0);
		add_flash(0, 0, 5);
		add_flash(0, 0, 5);
		send_req(tfbt_pkg::OP_TRACK, 0, 0, 0, 0, 10, 0, 5, 0, 0, 0);
		send_req(tfbt_pkg::OP_TRACK, 0, 0, 0, 5, 0, 0, 0, 10, 0, 0);
		send_req(tfbt_pkg::OP_TRACK, 0, 0, 0, 16'sh7fff, 16'sh8000, 16'sh7fff,
			16'sh8000, 16'sh7fff, 16'sh8000, 0);
		send_req(tfbt_pkg::OP_TRACK, 0, 0, 0, 3, 7, 1, 3, 7, -1, 1);
		drain();
		write_reg(tfbt_pkg::REG_MIN_LENGTH, 24'd100);
		cfg_we <= 0;
		send_req(tfbt_pkg::OP_TRACK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 99);
		send_req(tfbt_pkg::OP_TRACK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 100);
		repeat (70) add_flash(0, 0, 1);
		send_req(tfbt_pkg::OP_TRACK, 0, 0, 0, 0, 1, 0, 1, 0, 0, 200);
		send_req(tfbt_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		send_req(tfbt_pkg::OP_TRACK, 0, 0, 0, 0, 1, 0, 1, 0, 0, 200);
		drain();

		// random phases across register settings
		for (int ph = 0; ph < 6; ph++) begin
			quiet = (ph == 2);
			write_reg(tfbt_pkg::REG_CHARGE_THRESHOLD,
				ph == 0 ? 24'd0 : ph == 5 ? 24'hffff : 24'($urandom_range(0, 40000)));
			write_reg(tfbt_pkg::REG_MIN_LENGTH,
				ph == 0 ? 24'd0 : ph == 5 ? 24'hffff : 24'($urandom));
			write_reg(tfbt_pkg::REG_ANODE_REF,
				ph == 4 ? 24'h40000 : ph == 5 ? 24'h3ffff : 24'($urandom_range(0, 200)));
			write_reg(tfbt_pkg::REG_CATHODE_REF,
				ph == 4 ? 24'h3ffff : ph == 5 ? 24'h40000 : 24'($urandom_range(0, 300)));
			write_reg(tfbt_pkg::REG_ANODE_WIN,
				ph == 4 ? 24'h3ffff : ph == 1 ? 24'd0 : 24'($urandom_range(1, 300)));
			write_reg(tfbt_pkg::REG_CATHODE_WIN,
				ph == 4 ? 24'h0 : ph == 5 ? 24'h3ffff : 24'($urandom_range(1, 300)));
			write_reg(tfbt_pkg::REG_Z_WIN,
				ph == 4 ? 24'h7fff : ph == 1 ? 24'd0 : 24'($urandom_range(1, 400)));
			write_reg(tfbt_pkg::REG_INV_DRIFT,
				ph == 4 ? 24'hffffff : ph == 1 ? 24'd0 : 24'($urandom_range(0, 200000)));
			cfg_we <= 0;
			for (int k = 0; k < 250; k++) begin
				int r;
				r = $urandom_range(99);
				if (r < 3) rand_req(tfbt_pkg::OP_CLEAR);
				else if (r < 5) rand_req(tfbt_pkg::OP_NONE);
				else if (r < 55) rand_flash(r < 45);
				else rand_track(r < 90);
			end
			drain();
		end
		quiet = 0;

		if (fail_count == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

	initial begin
		#20ms;
		$display("FAIL");
		$finish;
	end
endmodule

`default_nettype wire
